// ----- rtl/rss_pkg.sv -----
// rss_pkg: shared types, constants and codes of the range shift selector.
// No dependencies; imported by rss_quant_err and range_shift_selector.
package rss_pkg;

  // Widest shift code the selector supports, in bits.
  localparam int MAX_SHIFT_BITS = 4;
  localparam int SHIFT_W        = MAX_SHIFT_BITS;
  localparam int SAMPLE_W       = 16;
  localparam int WIDTH_W        = 5;
  localparam int SFB_W          = 3;
  localparam int TOL_W          = 15;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int OUT_DATA_W     = 8;

  // Width at and above which no shifting takes place.
  localparam logic [WIDTH_W-1:0] WIDE_WIDTH = WIDTH_W'(SAMPLE_W);

  // Largest error value, starting point of the scan's running error.
  localparam logic signed [SAMPLE_W-1:0] ERR_MAX = 16'sh7FFF;

  // Register reset values.
  localparam logic [WIDTH_W-1:0] TARGET_WIDTH_RST = 5'd16;
  localparam logic [SFB_W-1:0]   SFB_RST          = 3'd3;
  localparam logic [TOL_W-1:0]   TOL_RST          = '0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURRENT_PRECISION = 2'd0,
    CFG_TARGET_WIDTH      = 2'd1,
    CFG_SHIFT_FIELD_BITS  = 2'd2,
    CFG_ERROR_TOLERANCE   = 2'd3
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREV,
    ST_SCAN,
    ST_DONE
  } rss_state_t;

  // Request to the quantization error unit.
  typedef struct packed {
    logic [SAMPLE_W-1:0]       mag;
    logic signed [SHIFT_W-1:0] shift;
    logic [WIDTH_W-1:0]        width;
  } rss_qreq_t;

endpackage

// ----- rtl/rss_quant_err.sv -----
// rss_quant_err: quantization error of a sample magnitude at one shift.
// Combinational shared unit; depends on rss_pkg.
module rss_quant_err import rss_pkg::*; (
  input  rss_qreq_t                    req,
  output logic signed [SAMPLE_W-1:0]   err
);

  logic signed [5:0]   c;
  logic [4:0]          neg_c;
  logic [31:0]         mask;
  logic [31:0]         mask_sh;
  logic [SAMPLE_W-1:0] q;

  // Shift count: 16 - width + shift
  assign c = 6'sd16 - $signed({1'b0, req.width}) + 6'(req.shift);
  assign neg_c = 5'(-c);

  // Value mask of the narrow word
  always_comb begin
    if (req.width == '0) begin
      mask = '0;
    end else begin
      mask = (32'd1 << (req.width - 5'd1)) - 32'd1;
    end
  end

  // Quantized value keeps the sample bits under the shifted mask, top bit dropped
  always_comb begin
    if (c > 6'sd0) begin
      mask_sh = mask << c[4:0];
    end else begin
      mask_sh = mask >> neg_c;
    end
  end

  assign q   = req.mag & {1'b0, mask_sh[SAMPLE_W-2:0]};
  // q never exceeds mag; a full-scale magnitude wraps to the most negative error
  assign err = $signed(req.mag - q);

endmodule

// ----- rtl/range_shift_selector.sv -----
// range_shift_selector: top level; picks the range shift per sample.
// Depends on rss_pkg and rss_quant_err.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready with the sample in s_tdata and the
//   sequence-start flag in s_tuser. Each beat yields exactly one output beat on
//   m_tvalid/m_tready carrying the chosen 4-bit shift in m_tdata.
//   Registers are written on cfg_valid/cfg_ready (always ready), by the user
//   only while idle; the block itself does not enforce it. Index 0
//   current_precision (no effect on the shift), 1 target_width,
//   2 shift_field_bits, 3 error_tolerance.
// Timing:
//   One error evaluation per cycle on the shared quantization unit. A beat is
//   accepted, the previous shift is checked and, if out of tolerance, shifts
//   2^(b-1)-1 down at most to -2^(b-1) are scanned (b = saturated field bits);
//   then the output register is loaded. A target width of 16 or more skips
//   evaluation. One beat at a time is taken; s_tready is high only when idle.
// Reset: registers 1-3 return to 16, 3, 0; the kept shift clears to 0; no beat
//   is pending. A stalled receiver holds the result in the output register;
//   the next beat is still taken, and its result waits until that slot frees.
module range_shift_selector import rss_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // s_tdata: [15:0] sample
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [SAMPLE_W-1:0]      s_tdata,
  // s_tuser: [0] first
  input  logic [0:0]               s_tuser,
  // m_tdata: [3:0] shift, [7:4] zero
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_W-1:0]    m_tdata,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  rss_state_t state, state_next;

  logic [WIDTH_W-1:0]           target_width;
  logic [SFB_W-1:0]             shift_field_bits;
  logic [TOL_W-1:0]             error_tolerance;
  logic signed [SHIFT_W-1:0]    last_shift;

  logic [SAMPLE_W-1:0]          mag;
  logic signed [SHIFT_W-1:0]    prev;
  logic signed [SHIFT_W-1:0]    s_cur;
  logic signed [SHIFT_W-1:0]    best_shift;
  logic signed [SHIFT_W-1:0]    res;
  logic signed [SHIFT_W-1:0]    shift_out;
  logic signed [SAMPLE_W-1:0]   prev_err;
  logic signed [SAMPLE_W-1:0]   best_err;
  logic signed [SAMPLE_W-1:0]   last_err;

  logic [SFB_W-1:0]             b_sat;
  logic [SHIFT_W:0]             half;
  logic signed [SHIFT_W-1:0]    scan_hi;
  logic signed [SHIFT_W-1:0]    scan_lo;
  logic                         wide;
  logic                         accept;
  logic                         out_free;
  logic                         load_out;
  logic                         within_tol;
  logic                         skip;
  logic                         better;
  logic                         stop;
  logic                         at_lo;
  logic signed [SAMPLE_W-1:0]   best_err_next;
  logic signed [SHIFT_W-1:0]    best_shift_next;
  logic [SAMPLE_W-1:0]          neg_sample;

  rss_qreq_t                    qreq;
  logic signed [SAMPLE_W-1:0]   err;

  // Configuration registers; current_precision cancels out and is not kept
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_width     <= TARGET_WIDTH_RST;
      shift_field_bits <= SFB_RST;
      error_tolerance  <= TOL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CURRENT_PRECISION: ;
        CFG_TARGET_WIDTH:      target_width     <= cfg_data[WIDTH_W-1:0];
        CFG_SHIFT_FIELD_BITS:  shift_field_bits <= cfg_data[SFB_W-1:0];
        CFG_ERROR_TOLERANCE:   error_tolerance  <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Scan range from the saturated shift field width
  always_comb begin
    if (shift_field_bits == '0) begin
      b_sat = SFB_W'(1);
    end else if (shift_field_bits > SFB_W'(MAX_SHIFT_BITS)) begin
      b_sat = SFB_W'(MAX_SHIFT_BITS);
    end else begin
      b_sat = shift_field_bits;
    end
  end

  assign half    = (SHIFT_W+1)'(1) << (b_sat - SFB_W'(1));
  assign scan_hi = SHIFT_W'(half - (SHIFT_W+1)'(1));
  assign scan_lo = SHIFT_W'(-half);
  assign wide    = (target_width >= WIDE_WIDTH);

  // Shared quantization error unit
  assign qreq.mag   = mag;
  assign qreq.shift = (state == ST_SCAN) ? s_cur : prev;
  assign qreq.width = target_width;

  rss_quant_err u_qerr (
    .req (qreq),
    .err (err)
  );

  // Decisions of the current step
  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign within_tol = (err <= $signed({1'b0, error_tolerance}));
  assign skip       = (s_cur == prev);
  assign better     = (err <= best_err);
  assign stop       = !skip && !better && (err >= last_err);
  assign at_lo      = (s_cur == scan_lo);

  assign best_err_next   = (!skip && better) ? err   : best_err;
  assign best_shift_next = (!skip && better) ? s_cur : best_shift;
  assign neg_sample      = SAMPLE_W'(-s_tdata);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = wide ? ST_DONE : ST_PREV;
        end
      end
      ST_PREV: begin
        state_next = within_tol ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (stop || at_lo) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          mag  <= s_tdata[SAMPLE_W-1] ? neg_sample : s_tdata;
          prev <= s_tuser[0] ? '0 : last_shift;
          res  <= '0;
        end
      end
      ST_PREV: begin
        prev_err   <= err;
        best_err   <= err;
        best_shift <= prev;
        last_err   <= ERR_MAX;
        s_cur      <= scan_hi;
        res        <= prev;
      end
      ST_SCAN: begin
        best_err   <= best_err_next;
        best_shift <= best_shift_next;
        if (!skip) begin
          last_err <= err;
        end
        s_cur <= s_cur - SHIFT_W'(1);
        res   <= (prev_err <= best_err_next) ? prev : best_shift_next;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Output register and kept shift
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      last_shift <= '0;
    end else begin
      if (load_out) begin
        m_tvalid   <= 1'b1;
        last_shift <= res;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      shift_out <= res;
    end
  end

  assign m_tdata = {(OUT_DATA_W-SHIFT_W)'(0), shift_out};

  // Checks on the sequencer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("beat accepted while one is in progress");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (s_cur >= scan_lo && s_cur <= scan_hi))
    else $error("scan shift out of range");

  a_best_not_worse: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (best_err <= prev_err))
    else $error("best error above previous error");

  a_wide_zero: assert property (@(posedge clk) disable iff (rst)
    (load_out && wide) |-> (res == '0))
    else $error("wide target gave nonzero shift");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid)
    else $error("result load lost");

endmodule

// ----- test/rss_checker.sv -----
`timescale 1ns / 100ps
// rss_checker: watches the sample, shift and register channels of range_shift_selector,
// predicts each shift and compares it with the output beat. Depends on rss_pkg.
module rss_checker import rss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,
  input  logic [0:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    shifts_pending
);

  // Shadow registers and kept shift
  logic [WIDTH_W-1:0]        width_q;
  logic [SFB_W-1:0]          sfb_q;
  logic [TOL_W-1:0]          tol_q;
  logic signed [SHIFT_W-1:0] kept_shift;

  logic signed [SHIFT_W-1:0] shift_expect_q[$];
  logic signed [SHIFT_W-1:0] want_shift;
  logic signed [SHIFT_W-1:0] got_shift;
  int                        errors = 0;

  // Magnitude error after quantizing at combined shift c, folded to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] quant_error_at(bit [31:0] mag, int c,
                                                               bit [31:0] mask);
    bit [31:0]                  q;
    logic signed [SAMPLE_W-1:0] d;
    if (c > 0) begin
      q = (mag >> c) & mask;
      q = (q << c) & 32'hFFFF;
    end else begin
      q = ((mag << (-c)) & mask) >> (-c);
    end
    q = q & 32'h7FFF;
    d = 16'(mag - q);
    // negating -32768 wraps back to itself
    if (d < 0) d = -d;
    return d;
  endfunction

  // Shift chosen for one sample given the previous shift
  function automatic logic signed [SHIFT_W-1:0] pick_shift(logic [SAMPLE_W-1:0] sample,
                                                           logic signed [SHIFT_W-1:0] prev);
    logic [SAMPLE_W-1:0] mag;
    bit [31:0]           mask;
    int                  b, base, prev_err, last_err, best_err, best, offset, s, e;
    if (width_q >= WIDE_WIDTH) return '0;
    b = sfb_q;
    if (b < 1) b = 1;
    if (b > MAX_SHIFT_BITS) b = MAX_SHIFT_BITS;
    mag  = sample[SAMPLE_W-1] ? 16'(-sample) : sample;
    mask = (width_q == 0) ? 32'd0 : (32'd1 << (width_q - 1)) - 32'd1;
    base = SAMPLE_W - int'(width_q);

    prev_err = quant_error_at({16'd0, mag}, base + prev, mask);
    if (prev_err <= int'(tol_q)) return prev;

    // scan downward, keep the lowest error, stop once it no longer falls
    last_err = ERR_MAX;
    best_err = prev_err;
    best     = prev;
    offset   = (1 << (b - 1)) + 1;
    for (int i = 1 << b; i > 0; i--) begin
      s = i - offset;
      if (s == prev) continue;
      e = quant_error_at({16'd0, mag}, base + s, mask);
      if (e <= best_err) begin
        best_err = e;
        best     = s;
      end else if (e >= last_err) begin
        break;
      end
      last_err = e;
    end
    if (prev_err <= best_err) return prev;
    return SHIFT_W'(best);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_q     = TARGET_WIDTH_RST;
      sfb_q       = SFB_RST;
      tol_q       = TOL_RST;
      kept_shift  = '0;
      shift_expect_q.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CURRENT_PRECISION: ;  // no effect on the shift
          CFG_TARGET_WIDTH:      width_q     = cfg_data[WIDTH_W-1:0];
          CFG_SHIFT_FIELD_BITS:  sfb_q       = cfg_data[SFB_W-1:0];
          CFG_ERROR_TOLERANCE:   tol_q       = cfg_data[TOL_W-1:0];
          default: ;
        endcase
      end

      // output beat against the oldest prediction
      if (m_tvalid && m_tready) begin
        got_shift = m_tdata[SHIFT_W-1:0];
        if (shift_expect_q.size() == 0) begin
          $error("shift: expected none, got %0d", got_shift);
          errors++;
        end else begin
          want_shift = shift_expect_q.pop_front();
          if (got_shift !== want_shift) begin
            $error("shift: expected %0d, got %0d", want_shift, got_shift);
            errors++;
          end
        end
        if (m_tdata[OUT_DATA_W-1:SHIFT_W] !== '0) begin
          $error("pad: expected 0, got %0h", m_tdata[OUT_DATA_W-1:SHIFT_W]);
          errors++;
        end
      end

      // input beat: predict and update the kept shift
      if (s_tvalid && s_tready) begin
        want_shift = pick_shift(s_tdata, s_tuser[0] ? 4'sd0 : kept_shift);
        kept_shift = want_shift;
        shift_expect_q.push_back(want_shift);
      end
    end
    mismatch_count <= errors;
    shifts_pending <= shift_expect_q.size();
  end

endmodule

// ----- test/tb_range_shift_selector.sv -----
`timescale 1ns / 100ps
// tb_range_shift_selector: drives samples and register writes into range_shift_selector
// with random gaps and stalls; rss_checker does the prediction. Depends on rss_pkg.
module tb_range_shift_selector import rss_pkg::*; ();

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata   = '0;   // [15:0] sample
  logic [0:0]            s_tuser   = '0;   // [0] first
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;          // [3:0] shift, [7:4] zero
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    mismatch_count;
  int                    shifts_pending;
  bit                    tx_steady = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  range_shift_selector i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  rss_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .shifts_pending(shifts_pending)
  );

  // Sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TOL_W-1:0] pick_tolerance();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 15'h7FFF;
    r = (1 << $urandom_range(0, 12)) - 1;
    return 15'($urandom_range(0, r));
  endfunction

  // Sample mix: raw, extremes, varied magnitude, small drift from the last one
  function automatic logic [SAMPLE_W-1:0] make_sample(logic [SAMPLE_W-1:0] last_smp);
    int m;
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom);
      3: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      4, 5, 6: begin
        m = $urandom_range(0, 32767) >> $urandom_range(0, 14);
        return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
      end
      default: return last_smp + 16'($urandom_range(0, 64)) - 16'd32;
    endcase
  endfunction

  // Leaves valid high; the caller lowers it after the last write
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(logic [3:0] prec, logic [WIDTH_W-1:0] width,
                               logic [SFB_W-1:0] sfb, logic [TOL_W-1:0] tol);
    write_reg(CFG_CURRENT_PRECISION, 16'(prec));
    write_reg(CFG_TARGET_WIDTH, 16'(width));
    write_reg(CFG_SHIFT_FIELD_BITS, 16'(sfb));
    write_reg(CFG_ERROR_TOLERANCE, 16'(tol));
    cfg_valid <= 1'b0;
  endtask

  // Valid stays high after the beat so back-to-back beats need no second edit
  task automatic send_sample(logic [SAMPLE_W-1:0] value, logic first);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (shifts_pending != 0);
  endtask

  // Receiver stalls, with long stretches of steady ready
  initial begin : rx_stall
    int r, stall, hold;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        stall = 0;
        hold  = $urandom_range(100, 300);
      end else begin
        stall = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        hold  = $urandom_range(1, 6);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat (hold) @(posedge clk);
    end
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int                  run_left;
    logic [SAMPLE_W-1:0] smp;
    logic                first_flag;
    smp = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: wide target, shift stays 0
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    wait_drained();

    // mid width, full sample range
    load_settings(4'd9, 5'd8, 3'd3, 15'd0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h4000, 1'b0);
    send_sample(16'h00FF, 1'b0);
    send_sample(16'h0100, 1'b0);
    send_sample(16'h1234, 1'b0);
    send_sample(16'h1234, 1'b1);
    wait_drained();

    // narrowest target, widest shift code: everything quantizes to zero
    load_settings(4'd15, 5'd1, 3'd4, 15'd0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0003, 1'b0);
    wait_drained();

    // one-bit shift code, tolerance wide open: previous shift always kept
    load_settings(4'd0, 5'd15, 3'd1, 15'h7FFF);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0055, 1'b0);
    wait_drained();

    load_settings(4'd5, 5'd12, 3'd2, 15'd3);
    send_sample(16'h0FFF, 1'b1);
    send_sample(16'hF001, 1'b0);
    send_sample(16'h2AAA, 1'b0);
    send_sample(16'h5555, 1'b0);
    wait_drained();

    // random phases: sequences opened by first, some broken ones mixed in
    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       load_settings(4'($urandom), 5'd1, 3'd1, 15'd0);
        1:       load_settings(4'($urandom), 5'd15, 3'd4, 15'h7FFF);
        2:       load_settings(4'($urandom), 5'd16, 3'($urandom_range(1, 4)), 15'($urandom));
        default: load_settings(4'($urandom), 5'($urandom_range(1, 16)),
                               3'($urandom_range(1, 4)), pick_tolerance());
      endcase
      tx_steady = (p % 4 == 3);
      run_left  = 0;
      for (int n = 0; n < 140; n++) begin
        if (run_left == 0) begin
          run_left   = $urandom_range(1, 24);
          first_flag = 1'b1;
        end else begin
          first_flag = 1'b0;
        end
        run_left--;
        if ($urandom_range(0, 9) == 0) first_flag = 1'($urandom_range(0, 1));
        smp = make_sample(smp);
        if ($urandom_range(0, 49) == 0) wait_drained();
        send_sample(smp, first_flag);
      end
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rss_pkg.sv
rtl/rss_quant_err.sv
rtl/range_shift_selector.sv
test/rss_checker.sv
test/tb_range_shift_selector.sv
